// ===== rtl/si_pkg.sv =====
// ----------------------------------------------------------------------------
// si_pkg: shared types and constants for the segment intersection pipeline
// Beat layouts, latencies and the fixed-point constants used by all modules.
// ----------------------------------------------------------------------------
package si_pkg;

	localparam int DIFF_W   = 33;              // difference of two Q16.16 values
	localparam int PROD_W   = 2 * DIFF_W;      // exact product of two differences
	localparam int WIDE_W   = PROD_W + 1;      // determinant and numerators
	localparam int FRAC_SH  = 16;
	localparam int QUO_BITS = 32;
	localparam int DIV_LAT  = QUO_BITS + 3;    // abs, range check, steps, saturate
	localparam int LERP_LAT = 2;
	localparam int PIPE_LAT = 3 + DIV_LAT + LERP_LAT + 1;

	localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
	localparam logic signed [31:0] Q_ZERO  = 32'sh0000_0000;
	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] d_x;
		logic signed [31:0] d_y;
	} item_t;

	typedef struct packed {
		logic signed [31:0] ab_fraction;
		logic signed [31:0] cd_fraction;
		logic signed [31:0] cross_x;
		logic signed [31:0] cross_y;
		logic               hit;
		logic               lines_parallel;
	} result_t;

	// values that ride alongside the dividers
	typedef struct packed {
		logic signed [31:0]       ax;
		logic signed [31:0]       ay;
		logic signed [DIFF_W-1:0] abx;
		logic signed [DIFF_W-1:0] aby;
		logic                     par;
	} side_t;

	// values that ride alongside the point interpolation
	typedef struct packed {
		logic signed [31:0] r;
		logic signed [31:0] s;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic               par;
	} tail_t;

endpackage

// ===== rtl/si_qdiv.sv =====
// ----------------------------------------------------------------------------
// si_qdiv: pipelined Q16.16 divider
// (num * 2^16) / den truncated toward zero and saturated to 32 bits signed.
// One quotient bit per stage; a new operand pair may enter every cycle.
// ----------------------------------------------------------------------------
module si_qdiv (
	input  logic                                clk,
	input  logic signed [si_pkg::WIDE_W-1:0]    num,
	input  logic signed [si_pkg::WIDE_W-1:0]    den,
	output logic signed [31:0]                  quo
);

	localparam int W  = si_pkg::WIDE_W;
	localparam int NB = si_pkg::QUO_BITS;
	localparam int SH = si_pkg::FRAC_SH;

	logic [W-1:0] nabs_s0;
	logic [W-1:0] dabs_s0;
	logic         neg_s0;

	logic [W-1:0]    rem_s  [NB+1];
	logic [NB-1:0]   dvd_s  [NB+1];
	logic [NB-1:0]   quo_s  [NB+1];
	logic [W-1:0]    den_s  [NB+1];
	logic            neg_s  [NB+1];
	logic            ovf_s  [NB+1];

	always_ff @(posedge clk) begin
		nabs_s0 <= num[W-1] ? W'(-num) : W'(num);
		dabs_s0 <= den[W-1] ? W'(-den) : W'(den);
		neg_s0  <= num[W-1] ^ den[W-1];
	end

	// quotient reaches 2^32 exactly when |num| >= |den| * 2^16
	always_ff @(posedge clk) begin
		ovf_s[0] <= nabs_s0 >= {dabs_s0[W-1-SH:0], {SH{1'b0}}} && dabs_s0[W-1:W-SH] == '0;
		rem_s[0] <= {{SH{1'b0}}, nabs_s0[W-1:SH]};
		dvd_s[0] <= {nabs_s0[SH-1:0], {(NB-SH){1'b0}}};
		quo_s[0] <= '0;
		den_s[0] <= dabs_s0;
		neg_s[0] <= neg_s0;
	end

	for (genvar k = 0; k < NB; k++) begin : g_step
		logic [W:0] trial;
		logic [W:0] diff;
		logic       ge;

		assign trial = {rem_s[k], dvd_s[k][NB-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[W-1:0] : trial[W-1:0];
			dvd_s[k+1] <= {dvd_s[k][NB-2:0], 1'b0};
			quo_s[k+1] <= {quo_s[k][NB-2:0], ge};
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (!neg_s[NB]) begin
			quo <= (ovf_s[NB] || quo_s[NB][NB-1]) ? si_pkg::SAT_MAX : $signed(quo_s[NB]);
		end else begin
			quo <= (ovf_s[NB] || quo_s[NB] > 32'h8000_0000) ? si_pkg::SAT_MIN
			       : $signed(-quo_s[NB]);
		end
	end

endmodule

// ===== rtl/si_lerp.sv =====
// ----------------------------------------------------------------------------
// si_lerp: point interpolation a + floor(r * delta / 2^16), saturated
// Two register stages: product, then shift, add and clamp.
// ----------------------------------------------------------------------------
module si_lerp (
	input  logic                                clk,
	input  logic signed [31:0]                  a,
	input  logic signed [31:0]                  r,
	input  logic signed [si_pkg::DIFF_W-1:0]    delta,
	output logic signed [31:0]                  pt
);

	localparam int PW = 32 + si_pkg::DIFF_W;
	localparam int FW = PW - si_pkg::FRAC_SH;
	localparam int SW = FW + 1;

	logic signed [PW-1:0] prod_s1;
	logic signed [31:0]   a_s1;
	logic signed [SW-1:0] sum;

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(r) * PW'(delta);
		a_s1    <= a;
	end

	// arithmetic shift gives the floor
	assign sum = SW'(a_s1) + SW'($signed(prod_s1[PW-1:si_pkg::FRAC_SH]));

	always_ff @(posedge clk) begin
		if (sum[SW-1:31] == '0 || sum[SW-1:31] == '1) begin
			pt <= sum[31:0];
		end else begin
			pt <= sum[SW-1] ? si_pkg::SAT_MIN : si_pkg::SAT_MAX;
		end
	end

endmodule

// ===== rtl/segment_intersection.sv =====
// ----------------------------------------------------------------------------
// segment_intersection: crossing of two 2D segments in Q16.16
// Determinant, two pipelined divisions, interpolated point and hit flag.
//
//   channel  | ports                  | handshake
//   ---------+------------------------+------------------------------
//   input    | item                   | beat taken when start && !busy
//   result   | result                 | one-cycle beat marked by done
//
// A segment pair may enter every cycle; busy never rises.
// The path runs through three arithmetic stages, the divider with one
// quotient bit per stage, two interpolation stages and the output register.
// Reset clears only the valid chain; data registers run free.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module segment_intersection (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  si_pkg::item_t     item,
	output logic              busy,
	output logic              done,
	output si_pkg::result_t   result
);

	localparam int DW = si_pkg::DIFF_W;
	localparam int PW = si_pkg::PROD_W;
	localparam int WW = si_pkg::WIDE_W;
	localparam int DL = si_pkg::DIV_LAT;
	localparam int PL = si_pkg::PIPE_LAT;

	logic [PL-1:0] vld_q;

	logic signed [DW-1:0] abx_s1, aby_s1, cdx_s1, cdy_s1, acx_s1, acy_s1;
	logic signed [31:0]   ax_s1, ay_s1;

	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [DW-1:0] abx_s2, aby_s2;
	logic signed [31:0]   ax_s2, ay_s2;

	logic signed [WW-1:0] det_s3, nr_s3, ns_s3;
	si_pkg::side_t        side_s3;
	logic signed [WW-1:0] neg_det;

	si_pkg::side_t        side_q [DL];
	logic signed [31:0]   r_q, s_q;
	logic signed [31:0]   px, py;
	si_pkg::tail_t        tail1_q, tail2_q;

	assign busy = 1'b0;
	assign done = vld_q[PL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PL-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		abx_s1 <= DW'(item.b_x) - DW'(item.a_x);
		aby_s1 <= DW'(item.b_y) - DW'(item.a_y);
		cdx_s1 <= DW'(item.d_x) - DW'(item.c_x);
		cdy_s1 <= DW'(item.d_y) - DW'(item.c_y);
		acx_s1 <= DW'(item.a_x) - DW'(item.c_x);
		acy_s1 <= DW'(item.a_y) - DW'(item.c_y);
		ax_s1  <= item.a_x;
		ay_s1  <= item.a_y;
	end

	always_ff @(posedge clk) begin
		p1_s2  <= PW'(abx_s1) * PW'(cdy_s1);
		p2_s2  <= PW'(aby_s1) * PW'(cdx_s1);
		p3_s2  <= PW'(acy_s1) * PW'(cdx_s1);
		p4_s2  <= PW'(acx_s1) * PW'(cdy_s1);
		p5_s2  <= PW'(acy_s1) * PW'(abx_s1);
		p6_s2  <= PW'(acx_s1) * PW'(aby_s1);
		abx_s2 <= abx_s1;
		aby_s2 <= aby_s1;
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;
	end

	always_ff @(posedge clk) begin
		det_s3      <= WW'(p1_s2) - WW'(p2_s2);
		nr_s3       <= WW'(p3_s2) - WW'(p4_s2);
		ns_s3       <= WW'(p6_s2) - WW'(p5_s2);
		side_s3.ax  <= ax_s2;
		side_s3.ay  <= ay_s2;
		side_s3.abx <= abx_s2;
		side_s3.aby <= aby_s2;
		side_s3.par <= p1_s2 == p2_s2;
	end

	assign neg_det = -det_s3;

	si_qdiv u_div_r (.clk(clk), .num(nr_s3), .den(det_s3),  .quo(r_q));
	si_qdiv u_div_s (.clk(clk), .num(ns_s3), .den(neg_det), .quo(s_q));

	// carry the endpoint data past the dividers
	always_ff @(posedge clk) begin
		side_q[0] <= side_s3;
		for (int i = 1; i < DL; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	si_lerp u_lerp_x (.clk(clk), .a(side_q[DL-1].ax), .r(r_q),
		.delta(side_q[DL-1].abx), .pt(px));
	si_lerp u_lerp_y (.clk(clk), .a(side_q[DL-1].ay), .r(r_q),
		.delta(side_q[DL-1].aby), .pt(py));

	always_ff @(posedge clk) begin
		tail1_q.r   <= r_q;
		tail1_q.s   <= s_q;
		tail1_q.ax  <= side_q[DL-1].ax;
		tail1_q.ay  <= side_q[DL-1].ay;
		tail1_q.par <= side_q[DL-1].par;
		tail2_q     <= tail1_q;
	end

	// parallel lines: fractions zero, point A, hit set
	always_ff @(posedge clk) begin
		if (tail2_q.par) begin
			result.ab_fraction <= si_pkg::Q_ZERO;
			result.cd_fraction <= si_pkg::Q_ZERO;
			result.cross_x     <= tail2_q.ax;
			result.cross_y     <= tail2_q.ay;
			result.hit         <= 1'b1;
		end else begin
			result.ab_fraction <= tail2_q.r;
			result.cd_fraction <= tail2_q.s;
			result.cross_x     <= px;
			result.cross_y     <= py;
			result.hit         <= tail2_q.r >= si_pkg::Q_ZERO && tail2_q.r <= si_pkg::Q_ONE
			                   && tail2_q.s >= si_pkg::Q_ZERO && tail2_q.s <= si_pkg::Q_ONE;
		end
		result.lines_parallel <= tail2_q.par;
	end

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, si_pkg::PIPE_LAT))
		else $error("result beat without a matching input beat");

	a_parallel_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.lines_parallel |-> result.hit
			&& result.ab_fraction == si_pkg::Q_ZERO && result.cd_fraction == si_pkg::Q_ZERO)
		else $error("parallel beat with nonzero fractions or no hit");

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit |-> result.ab_fraction >= si_pkg::Q_ZERO
			&& result.ab_fraction <= si_pkg::Q_ONE)
		else $error("hit with ab fraction out of range");

endmodule
